/* sv/ucer_pkg.sv */
// Shared types, codes and descriptor tables for the endpoint-0 control responder.
package ucer_pkg;

    typedef logic [2:0] step_t;

    // Microprogram step addresses
    localparam step_t STEP_IDLE       = 3'd0;
    localparam step_t STEP_DATA_START = 3'd1;
    localparam step_t STEP_DATA_BYTE  = 3'd2;
    localparam step_t STEP_ACK_LAST   = 3'd3;
    localparam step_t STEP_CFG_ACK    = 3'd4;
    localparam step_t STEP_ONLINE     = 3'd5;
    localparam step_t STEP_STALL      = 3'd6;
    localparam step_t STEP_ADDR       = 3'd7;

    typedef enum logic [2:0] {
        KIND_DATA   = 3'd0,
        KIND_ACK    = 3'd1,
        KIND_STALL  = 3'd2,
        KIND_ADDR   = 3'd3,
        KIND_ONLINE = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        LAST_NO,
        LAST_YES,
        LAST_AT_END
    } last_sel_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_DISPATCH,
        COND_EMPTY,
        COND_MORE
    } cond_t;

    typedef struct packed {
        logic      emit;
        kind_t     kind;
        last_sel_t last_sel;
        cond_t     cond;
        logic      ret;
        step_t     target;
    } uword_t;

    typedef enum logic [2:0] {
        PH_ACK_ADDR  = 3'd0,
        PH_ACK       = 3'd1,
        PH_STATUS_RX = 3'd4,
        PH_IDLE      = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        SRC_STATUS,
        SRC_DEV,
        SRC_CFG
    } src_t;

    localparam logic [15:0] REQ_GET_STATUS        = 16'h0080;
    localparam logic [15:0] REQ_GET_DESCRIPTOR    = 16'h0680;
    localparam logic [15:0] REQ_SET_ADDRESS       = 16'h0500;
    localparam logic [15:0] REQ_SET_CONFIGURATION = 16'h0900;

    localparam logic [15:0] DESC_DEVICE = 16'h0100;
    localparam logic [15:0] DESC_CONFIG = 16'h0200;

    localparam logic [1:0] CFG_VENDOR_ID        = 2'd0;
    localparam logic [1:0] CFG_PRODUCT_ID       = 2'd1;
    localparam logic [1:0] CFG_SECOND_INTERFACE = 2'd2;

    localparam logic [5:0] LEN_STATUS  = 6'd2;
    localparam logic [5:0] LEN_DEVICE  = 6'd18;
    localparam logic [5:0] LEN_CFG_ONE = 6'd32;
    localparam logic [5:0] LEN_CFG_TWO = 6'd55;

    typedef struct packed {
        step_t dispatch;
        logic  empty;
        logic  last_byte;
        logic  out_free;
    } dp_status_t;

    typedef struct packed {
        logic  take;
        logic  emit;
        kind_t kind;
        logic  last;
    } seq_ctrl_t;

    // Interface plus two bulk endpoints, 23 bytes
    function automatic logic [7:0] ifc_byte(input logic [4:0] i);
        logic [7:0] b;
        unique case (i)
            5'd0:  b = 8'd9;
            5'd1:  b = 8'd4;
            5'd4:  b = 8'h02;
            5'd5:  b = 8'hFF;
            5'd9:  b = 8'd7;
            5'd10: b = 8'd5;
            5'd11: b = 8'h81;
            5'd12: b = 8'h02;
            5'd13: b = 8'h40;
            5'd16: b = 8'd7;
            5'd17: b = 8'd5;
            5'd18: b = 8'h01;
            5'd19: b = 8'h02;
            5'd20: b = 8'h40;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] desc_byte(input src_t src, input logic [5:0] idx,
                                             input logic [15:0] vid, input logic [15:0] pid,
                                             input logic second);
        logic [7:0] b;
        logic [5:0] off;
        b = 8'h00;
        off = 6'd0;
        unique case (src)
            SRC_DEV:
            begin
                unique case (idx)
                    6'd0:  b = 8'd18;
                    6'd1:  b = 8'd1;
                    6'd2:  b = 8'h10;
                    6'd3:  b = 8'h01;
                    6'd4:  b = 8'hFF;
                    6'd7:  b = 8'h40;
                    6'd8:  b = vid[7:0];
                    6'd9:  b = vid[15:8];
                    6'd10: b = pid[7:0];
                    6'd11: b = pid[15:8];
                    6'd12: b = 8'h10;
                    6'd13: b = 8'h01;
                    6'd17: b = 8'h01;
                    default: b = 8'h00;
                endcase
            end
            SRC_CFG:
            begin
                if (idx < 6'd9)
                begin
                    unique case (idx)
                        6'd0: b = 8'd9;
                        6'd1: b = 8'd2;
                        6'd2: b = second ? 8'h37 : 8'h20;
                        6'd4: b = second ? 8'h02 : 8'h01;
                        6'd5: b = 8'h01;
                        6'd7: b = 8'h80;
                        6'd8: b = 8'd50;
                        default: b = 8'h00;
                    endcase
                end
                else if (idx < 6'd32)
                begin
                    off = idx - 6'd9;
                    b = ifc_byte(off[4:0]);
                end
                else
                begin
                    // second interface: number 1, endpoints 0x82 and 0x02
                    off = idx - 6'd32;
                    unique case (off)
                        6'd2:  b = 8'h01;
                        6'd11: b = 8'h82;
                        6'd18: b = 8'h02;
                        default: b = ifc_byte(off[4:0]);
                    endcase
                end
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* sv/ucer_seq.sv */
// Microcode sequencer: step counter, control ROM and jump logic.
module ucer_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  ucer_pkg::dp_status_t  status,
    output ucer_pkg::seq_ctrl_t   ctrl
);

    function automatic ucer_pkg::uword_t ucode(input ucer_pkg::step_t s);
        ucer_pkg::uword_t w;
        w = '{emit: 1'b0, kind: ucer_pkg::KIND_DATA, last_sel: ucer_pkg::LAST_NO,
              cond: ucer_pkg::COND_NONE, ret: 1'b1, target: ucer_pkg::STEP_IDLE};
        unique case (s)
            ucer_pkg::STEP_IDLE:
            begin
                w.cond = ucer_pkg::COND_DISPATCH;
            end
            ucer_pkg::STEP_DATA_START:
            begin
                w.cond   = ucer_pkg::COND_EMPTY;
                w.ret    = 1'b0;
                w.target = ucer_pkg::STEP_ACK_LAST;
            end
            ucer_pkg::STEP_DATA_BYTE:
            begin
                w.emit     = 1'b1;
                w.last_sel = ucer_pkg::LAST_AT_END;
                w.cond     = ucer_pkg::COND_MORE;
                w.target   = ucer_pkg::STEP_DATA_BYTE;
            end
            ucer_pkg::STEP_ACK_LAST:
            begin
                w.emit     = 1'b1;
                w.kind     = ucer_pkg::KIND_ACK;
                w.last_sel = ucer_pkg::LAST_YES;
            end
            ucer_pkg::STEP_CFG_ACK:
            begin
                w.emit = 1'b1;
                w.kind = ucer_pkg::KIND_ACK;
                w.ret  = 1'b0;
            end
            ucer_pkg::STEP_ONLINE:
            begin
                w.emit     = 1'b1;
                w.kind     = ucer_pkg::KIND_ONLINE;
                w.last_sel = ucer_pkg::LAST_YES;
            end
            ucer_pkg::STEP_STALL:
            begin
                w.emit     = 1'b1;
                w.kind     = ucer_pkg::KIND_STALL;
                w.last_sel = ucer_pkg::LAST_YES;
            end
            ucer_pkg::STEP_ADDR:
            begin
                w.emit     = 1'b1;
                w.kind     = ucer_pkg::KIND_ADDR;
                w.last_sel = ucer_pkg::LAST_YES;
            end
            default: w.cond = ucer_pkg::COND_DISPATCH;
        endcase
        return w;
    endfunction

    ucer_pkg::step_t  pc_reg;
    ucer_pkg::step_t  pc_next;
    ucer_pkg::uword_t uw;
    ucer_pkg::step_t  fall;
    logic             hold;

    always_comb
    begin
        uw   = ucode(pc_reg);
        hold = uw.emit && !status.out_free;
        fall = uw.ret ? ucer_pkg::STEP_IDLE : pc_reg + 3'd1;

        ctrl.take = (uw.cond == ucer_pkg::COND_DISPATCH);
        ctrl.emit = uw.emit && status.out_free;
        ctrl.kind = uw.kind;
        unique case (uw.last_sel)
            ucer_pkg::LAST_YES:    ctrl.last = 1'b1;
            ucer_pkg::LAST_AT_END: ctrl.last = status.last_byte;
            default:               ctrl.last = 1'b0;
        endcase

        if (hold)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            unique case (uw.cond)
                ucer_pkg::COND_DISPATCH: pc_next = in_valid ? status.dispatch : pc_reg;
                ucer_pkg::COND_EMPTY:    pc_next = status.empty ? uw.target : fall;
                ucer_pkg::COND_MORE:     pc_next = !status.last_byte ? uw.target : fall;
                default:                 pc_next = fall;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= ucer_pkg::STEP_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

/* sv/ucer_dp.sv */
// Datapath: request decode, control state, byte counter and result register.
module ucer_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    input  logic                 opcode,
    input  logic [15:0]          request_word,
    input  logic [15:0]          request_value,
    input  logic [15:0]          request_length,
    input  logic                 out_ready,
    input  ucer_pkg::seq_ctrl_t  ctrl,
    output ucer_pkg::dp_status_t status,
    output logic                 out_valid,
    output logic [2:0]           reply_kind,
    output logic [7:0]           data_byte,
    output logic                 last,
    output logic [6:0]           device_address,
    output logic                 online
);

    logic [15:0]       vendor_id_reg;
    logic [15:0]       product_id_reg;
    logic              second_reg;
    ucer_pkg::phase_t  phase_reg;
    ucer_pkg::phase_t  phase_next;
    logic [6:0]        pending_reg;
    logic [6:0]        pending_next;
    logic [6:0]        current_reg;
    logic [6:0]        current_next;
    logic              online_reg;
    logic              online_next;
    ucer_pkg::src_t    src_reg;
    ucer_pkg::src_t    src_next;
    logic [5:0]        count_reg;
    logic [5:0]        count_next;
    logic [5:0]        idx_reg;
    logic [5:0]        idx_next;

    logic              out_valid_reg;
    logic [2:0]        kind_reg;
    logic [7:0]        byte_reg;
    logic              last_reg;
    logic [6:0]        addr_reg;
    logic              onl_reg;

    logic              accept;
    logic [5:0]        len;
    logic              is_data;
    ucer_pkg::step_t   dispatch;

    assign accept = in_valid && ctrl.take;

    always_comb
    begin
        dispatch     = ucer_pkg::STEP_STALL;
        phase_next   = phase_reg;
        pending_next = pending_reg;
        current_next = current_reg;
        online_next  = online_reg;
        src_next     = src_reg;
        len          = ucer_pkg::LEN_STATUS;
        is_data      = 1'b0;

        if (opcode)
        begin
            phase_next = ucer_pkg::PH_IDLE;
            if (phase_reg == ucer_pkg::PH_ACK_ADDR)
            begin
                current_next = pending_reg;
                dispatch     = ucer_pkg::STEP_ADDR;
            end
            else
            begin
                dispatch = ucer_pkg::STEP_IDLE;
            end
        end
        else
        begin
            unique case (request_word)
                ucer_pkg::REQ_GET_STATUS:
                begin
                    is_data  = 1'b1;
                    src_next = ucer_pkg::SRC_STATUS;
                    len      = ucer_pkg::LEN_STATUS;
                end
                ucer_pkg::REQ_GET_DESCRIPTOR:
                begin
                    if (request_value == ucer_pkg::DESC_DEVICE)
                    begin
                        is_data  = 1'b1;
                        src_next = ucer_pkg::SRC_DEV;
                        len      = ucer_pkg::LEN_DEVICE;
                    end
                    else if (request_value == ucer_pkg::DESC_CONFIG)
                    begin
                        is_data  = 1'b1;
                        src_next = ucer_pkg::SRC_CFG;
                        len      = second_reg ? ucer_pkg::LEN_CFG_TWO : ucer_pkg::LEN_CFG_ONE;
                    end
                end
                ucer_pkg::REQ_SET_ADDRESS:
                begin
                    pending_next = request_value[6:0];
                    phase_next   = ucer_pkg::PH_ACK_ADDR;
                    dispatch     = ucer_pkg::STEP_ACK_LAST;
                end
                ucer_pkg::REQ_SET_CONFIGURATION:
                begin
                    online_next = (request_value == 16'd1);
                    phase_next  = ucer_pkg::PH_ACK;
                    dispatch    = ucer_pkg::STEP_CFG_ACK;
                end
                default: dispatch = ucer_pkg::STEP_STALL;
            endcase
            if (is_data)
            begin
                phase_next = ucer_pkg::PH_STATUS_RX;
                dispatch   = ucer_pkg::STEP_DATA_START;
            end
        end
    end

    // reply length clipped to the host's wLength
    assign count_next = (request_length < {10'd0, len}) ? request_length[5:0] : len;

    assign status.dispatch  = dispatch;
    assign status.empty     = (count_reg == 6'd0);
    assign status.last_byte = (idx_reg == count_reg - 6'd1);
    assign status.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
            idx_next = 6'd0;
        else if (ctrl.emit && ctrl.kind == ucer_pkg::KIND_DATA)
            idx_next = idx_reg + 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vendor_id_reg  <= 16'h18D1;
            product_id_reg <= 16'h6502;
            second_reg     <= 1'b0;
            phase_reg      <= ucer_pkg::PH_IDLE;
            pending_reg    <= 7'd0;
            current_reg    <= 7'd0;
            online_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ucer_pkg::CFG_VENDOR_ID:        vendor_id_reg  <= cfg_data;
                    ucer_pkg::CFG_PRODUCT_ID:       product_id_reg <= cfg_data;
                    ucer_pkg::CFG_SECOND_INTERFACE: second_reg     <= cfg_data[0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                phase_reg   <= phase_next;
                pending_reg <= pending_next;
                current_reg <= current_next;
                online_reg  <= online_next;
            end
            if (ctrl.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (accept)
        begin
            src_reg   <= src_next;
            count_reg <= count_next;
        end
        if (ctrl.emit)
        begin
            kind_reg <= ctrl.kind;
            last_reg <= ctrl.last;
            byte_reg <= (ctrl.kind == ucer_pkg::KIND_DATA)
                        ? ucer_pkg::desc_byte(src_reg, idx_reg, vendor_id_reg,
                                              product_id_reg, second_reg)
                        : 8'h00;
            addr_reg <= (ctrl.kind == ucer_pkg::KIND_ADDR) ? current_reg : 7'd0;
            onl_reg  <= (ctrl.kind == ucer_pkg::KIND_ONLINE) ? online_reg : 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign reply_kind     = kind_reg;
    assign data_byte      = byte_reg;
    assign last           = last_reg;
    assign device_address = addr_reg;
    assign online         = onl_reg;

endmodule

/* sv/usb_control_endpoint_responder_unit.sv */
// Top level of the USB endpoint-0 control request responder.
// Takes SETUP packets and IN-complete events one at a time and answers with a
// stream of result items: descriptor or status bytes (cut to wLength, a zero-length
// ack when that leaves nothing), acks, stalls, address-applied and online-changed
// reports. in_ready is high only while the microcode sequencer sits at its idle step,
// from which an item is dispatched; a data reply then passes a step that checks the
// reply length, then emits its results (up to 55 for the two-interface configuration
// descriptor). Results leave through a single output register; a stalled consumer
// holds the sequencer in place. The user must write the configuration registers
// through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module usb_control_endpoint_responder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] request_word,
    input  logic [15:0] request_value,
    input  logic [15:0] request_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  reply_kind,
    output logic [7:0]  data_byte,
    output logic        last,
    output logic [6:0]  device_address,
    output logic        online
);

    ucer_pkg::dp_status_t status;
    ucer_pkg::seq_ctrl_t  ctrl;

    ucer_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .ctrl     (ctrl)
    );

    ucer_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .opcode         (opcode),
        .request_word   (request_word),
        .request_value  (request_value),
        .request_length (request_length),
        .out_ready      (out_ready),
        .ctrl           (ctrl),
        .status         (status),
        .out_valid      (out_valid),
        .reply_kind     (reply_kind),
        .data_byte      (data_byte),
        .last           (last),
        .device_address (device_address),
        .online         (online)
    );

    assign in_ready = ctrl.take;

endmodule

/* tb/usb_control_endpoint_responder_unit_test.sv */
// Testbench for the endpoint-0 control responder: directed requests, then random traffic.
module usb_control_endpoint_responder_unit_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 64;

    typedef enum logic [1:0] {
        BODY_STATUS,
        BODY_DEVICE,
        BODY_CONFIG
    } reply_body_t;

    typedef struct packed {
        ucer_pkg::kind_t kind;
        logic [7:0]      data;
        logic            last;
        logic [6:0]      addr;
        logic            onl;
    } control_reply_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [15:0] request_word;
    logic [15:0] request_value;
    logic [15:0] request_length;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  reply_kind;
    logic [7:0]  data_byte;
    logic        last;
    logic [6:0]  device_address;
    logic        online;

    control_reply_t replies_due[$];
    control_reply_t head_reply;
    int             mismatch_count;
    int             cycle_count;
    int             items_sent;
    logic           idle_enable;

    // mirror of the block state and its settings
    ucer_pkg::phase_t model_phase;
    logic [6:0]       model_pending_addr;
    logic [6:0]       model_addr;
    logic             model_online;
    logic [15:0]      setting_vendor;
    logic [15:0]      setting_product;
    logic             setting_second;

    usb_control_endpoint_responder_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .request_word   (request_word),
        .request_value  (request_value),
        .request_length (request_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reply_kind     (reply_kind),
        .data_byte      (data_byte),
        .last           (last),
        .device_address (device_address),
        .online         (online)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d replies still due", $time, replies_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= !idle_enable || ($urandom_range(99) >= 23);
    end

    function automatic void add_reply(ucer_pkg::kind_t k, logic [7:0] d, logic l,
                                      logic [6:0] a, logic o);
        control_reply_t r;
        r.kind = k;
        r.data = d;
        r.last = l;
        r.addr = a;
        r.onl = o;
        replies_due.push_back(r);
    endfunction

    function automatic logic [7:0] device_desc_byte(int i);
        logic [7:0] b;
        case (i)
            0:  b = 8'd18;
            1:  b = 8'd1;
            2:  b = 8'h10;
            3:  b = 8'h01;
            4:  b = 8'hFF;
            7:  b = 8'h40;
            8:  b = setting_vendor[7:0];
            9:  b = setting_vendor[15:8];
            10: b = setting_product[7:0];
            11: b = setting_product[15:8];
            12: b = 8'h10;
            13: b = 8'h01;
            17: b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // interface descriptor followed by its IN and OUT bulk endpoints
    function automatic logic [7:0] bulk_interface_byte(int i, logic [7:0] number,
                                                       logic [7:0] ep_in, logic [7:0] ep_out);
        logic [7:0] b;
        case (i)
            0:  b = 8'd9;
            1:  b = 8'd4;
            2:  b = number;
            4:  b = 8'h02;
            5:  b = 8'hFF;
            9:  b = 8'd7;
            10: b = 8'd5;
            11: b = ep_in;
            12: b = 8'h02;
            13: b = 8'h40;
            16: b = 8'd7;
            17: b = 8'd5;
            18: b = ep_out;
            19: b = 8'h02;
            20: b = 8'h40;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] config_desc_byte(int i);
        logic [7:0] b;
        b = 8'h00;
        if (i < 9)
        begin
            case (i)
                0: b = 8'd9;
                1: b = 8'd2;
                2: b = setting_second ? 8'h37 : 8'h20;
                4: b = setting_second ? 8'h02 : 8'h01;
                5: b = 8'h01;
                7: b = 8'h80;
                8: b = 8'd50;
                default: b = 8'h00;
            endcase
        end
        else if (i < 32)
            b = bulk_interface_byte(i - 9, 8'h00, 8'h81, 8'h01);
        else
            b = bulk_interface_byte(i - 32, 8'h01, 8'h82, 8'h02);
        return b;
    endfunction

    // data stage cut to wLength; nothing left means a zero-length ack
    function automatic void queue_reply_bytes(reply_body_t body, int total, logic [15:0] len);
        int n;
        logic [7:0] b;
        n = (int'(len) < total) ? int'(len) : total;
        if (n == 0)
            add_reply(ucer_pkg::KIND_ACK, 8'h00, 1'b1, 7'd0, 1'b0);
        for (int i = 0; i < n; i++)
        begin
            case (body)
                BODY_DEVICE: b = device_desc_byte(i);
                BODY_CONFIG: b = config_desc_byte(i);
                default:     b = 8'h00;
            endcase
            add_reply(ucer_pkg::KIND_DATA, b, i == n - 1, 7'd0, 1'b0);
        end
    endfunction

    function automatic void predict_endpoint_reply(logic op, logic [15:0] req,
                                                   logic [15:0] val, logic [15:0] len);
        if (op)
        begin
            if (model_phase == ucer_pkg::PH_ACK_ADDR)
            begin
                model_addr = model_pending_addr;
                add_reply(ucer_pkg::KIND_ADDR, 8'h00, 1'b1, model_addr, 1'b0);
            end
            model_phase = ucer_pkg::PH_IDLE;
        end
        else if (req == ucer_pkg::REQ_GET_STATUS)
        begin
            queue_reply_bytes(BODY_STATUS, 2, len);
            model_phase = ucer_pkg::PH_STATUS_RX;
        end
        else if (req == ucer_pkg::REQ_GET_DESCRIPTOR && val == ucer_pkg::DESC_DEVICE)
        begin
            queue_reply_bytes(BODY_DEVICE, 18, len);
            model_phase = ucer_pkg::PH_STATUS_RX;
        end
        else if (req == ucer_pkg::REQ_GET_DESCRIPTOR && val == ucer_pkg::DESC_CONFIG)
        begin
            queue_reply_bytes(BODY_CONFIG, setting_second ? 55 : 32, len);
            model_phase = ucer_pkg::PH_STATUS_RX;
        end
        else if (req == ucer_pkg::REQ_SET_ADDRESS)
        begin
            add_reply(ucer_pkg::KIND_ACK, 8'h00, 1'b1, 7'd0, 1'b0);
            model_pending_addr = val[6:0];
            model_phase = ucer_pkg::PH_ACK_ADDR;
        end
        else if (req == ucer_pkg::REQ_SET_CONFIGURATION)
        begin
            model_online = (val == 16'd1);
            add_reply(ucer_pkg::KIND_ACK, 8'h00, 1'b0, 7'd0, 1'b0);
            add_reply(ucer_pkg::KIND_ONLINE, 8'h00, 1'b1, 7'd0, model_online);
            model_phase = ucer_pkg::PH_ACK;
        end
        else
        begin
            // unknown request or descriptor type: stall, phase kept
            add_reply(ucer_pkg::KIND_STALL, 8'h00, 1'b1, 7'd0, 1'b0);
        end
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: reply with none due, expected nothing, got kind %0d byte %0h",
                         $time, reply_kind, data_byte);
                mismatch_count++;
            end
            else
            begin
                head_reply = replies_due.pop_front();
                check_field("reply_kind", 8'(head_reply.kind), 8'(reply_kind));
                check_field("data_byte", head_reply.data, data_byte);
                check_field("last", 8'(head_reply.last), 8'(last));
                check_field("device_address", 8'(head_reply.addr), 8'(device_address));
                check_field("online", 8'(head_reply.onl), 8'(online));
            end
        end
    end

    task automatic send_item(logic op, logic [15:0] req, logic [15:0] val, logic [15:0] len);
        @(negedge clk);
        while (idle_enable && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        request_word <= req;
        request_value <= val;
        request_length <= len;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_endpoint_reply(op, req, val, len);
        items_sent++;
    endtask

    task automatic send_in_complete();
        send_item(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // hold off new items until every due reply is out and the block has settled
    task automatic drain_replies();
        @(negedge clk);
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_setting(logic [1:0] index, logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        case (index)
            ucer_pkg::CFG_VENDOR_ID:        setting_vendor = value;
            ucer_pkg::CFG_PRODUCT_ID:       setting_product = value;
            ucer_pkg::CFG_SECOND_INTERFACE: setting_second = value[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(logic [15:0] vid, logic [15:0] pid, logic second);
        drain_replies();
        write_setting(ucer_pkg::CFG_VENDOR_ID, vid);
        write_setting(ucer_pkg::CFG_PRODUCT_ID, pid);
        write_setting(ucer_pkg::CFG_SECOND_INTERFACE, {15'd0, second});
    endtask

    task automatic test_status_reply();
        send_item(1'b0, ucer_pkg::REQ_GET_STATUS, 16'h0000, 16'd0);
        send_item(1'b0, ucer_pkg::REQ_GET_STATUS, 16'hFFFF, 16'd1);
        send_item(1'b0, ucer_pkg::REQ_GET_STATUS, 16'h0000, 16'hFFFF);
    endtask

    task automatic test_device_descriptor();
        send_item(1'b0, ucer_pkg::REQ_GET_DESCRIPTOR, ucer_pkg::DESC_DEVICE, 16'd0);
        send_item(1'b0, ucer_pkg::REQ_GET_DESCRIPTOR, ucer_pkg::DESC_DEVICE, 16'd1);
        send_item(1'b0, ucer_pkg::REQ_GET_DESCRIPTOR, ucer_pkg::DESC_DEVICE, 16'd18);
    endtask

    task automatic test_descriptor_settings();
        apply_settings(16'h0000, 16'hFFFF, 1'b0);
        send_item(1'b0, ucer_pkg::REQ_GET_DESCRIPTOR, ucer_pkg::DESC_DEVICE, 16'hFFFF);
        send_item(1'b0, ucer_pkg::REQ_GET_DESCRIPTOR, ucer_pkg::DESC_CONFIG, 16'hFFFF);
        apply_settings(16'hFFFF, 16'h0000, 1'b1);
        send_item(1'b0, ucer_pkg::REQ_GET_DESCRIPTOR, ucer_pkg::DESC_DEVICE, 16'd12);
        send_item(1'b0, ucer_pkg::REQ_GET_DESCRIPTOR, ucer_pkg::DESC_CONFIG, 16'hFFFF);
        send_item(1'b0, ucer_pkg::REQ_GET_DESCRIPTOR, ucer_pkg::DESC_CONFIG, 16'd54);
    endtask

    task automatic test_bad_descriptor();
        send_item(1'b0, ucer_pkg::REQ_GET_DESCRIPTOR, 16'h0300, 16'd64);
        send_item(1'b0, ucer_pkg::REQ_GET_DESCRIPTOR, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_address_handoff();
        send_item(1'b0, ucer_pkg::REQ_SET_ADDRESS, 16'hFFFF, 16'hFFFF);
        send_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // second completion finds the phase idle: no result
        send_item(1'b1, 16'h0000, 16'h0000, 16'h0000);
        send_item(1'b0, ucer_pkg::REQ_SET_ADDRESS, 16'h0005, 16'd0);
        // a new setup overrides the pending address hand-off
        send_item(1'b0, ucer_pkg::REQ_GET_STATUS, 16'h0000, 16'd2);
        send_in_complete();
    endtask

    task automatic test_configuration();
        send_item(1'b0, ucer_pkg::REQ_SET_CONFIGURATION, 16'h0001, 16'd0);
        send_item(1'b0, ucer_pkg::REQ_SET_CONFIGURATION, 16'h0000, 16'd0);
        send_item(1'b0, ucer_pkg::REQ_SET_CONFIGURATION, 16'h0101, 16'hFFFF);
    endtask

    task automatic test_unknown_request();
        send_item(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(1'b0, 16'h0000, 16'h0100, 16'd18);
    endtask

    function automatic logic [15:0] random_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return 16'd0;
        else if (pick < 55)
            return 16'($urandom_range(60));
        else if (pick < 65)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // mostly complete control transfers: a valid setup, then its IN completion
    task automatic random_exchange();
        int pick;
        logic [15:0] req;
        logic [15:0] val;
        pick = $urandom_range(99);
        val = 16'($urandom);
        if (pick < 72)
        begin
            case ($urandom_range(3))
                0: req = ucer_pkg::REQ_GET_STATUS;
                1:
                begin
                    req = ucer_pkg::REQ_GET_DESCRIPTOR;
                    pick = $urandom_range(99);
                    if (pick < 45)
                        val = ucer_pkg::DESC_DEVICE;
                    else if (pick < 90)
                        val = ucer_pkg::DESC_CONFIG;
                end
                2: req = ucer_pkg::REQ_SET_ADDRESS;
                default:
                begin
                    req = ucer_pkg::REQ_SET_CONFIGURATION;
                    pick = $urandom_range(99);
                    if (pick < 50)
                        val = 16'd1;
                    else if (pick < 75)
                        val = 16'd0;
                end
            endcase
            send_item(1'b0, req, val, random_length());
            if ($urandom_range(99) < 80)
                send_in_complete();
        end
        else if (pick < 86)
            send_in_complete();
        else
            send_item(1'b0, 16'($urandom), val, random_length());
    endtask

    task automatic test_random_traffic(int count, logic idling);
        int target;
        target = items_sent + count;
        idle_enable = idling;
        while (items_sent < target)
            random_exchange();
        drain_replies();
        idle_enable = 1'b1;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ucer_pkg::CFG_VENDOR_ID;
        cfg_data = 16'h0000;
        in_valid = 1'b0;
        opcode = 1'b0;
        request_word = 16'h0000;
        request_value = 16'h0000;
        request_length = 16'h0000;
        out_ready = 1'b0;
        idle_enable = 1'b1;
        mismatch_count = 0;
        cycle_count = 0;
        items_sent = 0;
        model_phase = ucer_pkg::PH_IDLE;
        model_pending_addr = 7'd0;
        model_addr = 7'd0;
        model_online = 1'b0;
        setting_vendor = 16'h18D1;
        setting_product = 16'h6502;
        setting_second = 1'b0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_status_reply();
        test_device_descriptor();
        test_descriptor_settings();
        test_bad_descriptor();
        test_address_handoff();
        test_configuration();
        test_unknown_request();

        apply_settings(16'($urandom), 16'($urandom), 1'b0);
        test_random_traffic(140, 1'b1);
        apply_settings(16'($urandom), 16'($urandom), 1'b1);
        test_random_traffic(140, 1'b0);
        apply_settings(16'($urandom), 16'($urandom), 1'($urandom));
        test_random_traffic(70, 1'b1);
        test_random_traffic(70, 1'b1);

        drain_replies();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
